// ===== rtl/wft_pkg.sv =====
// Shared types and constants for the WebSocket frame transmitter.
package wft_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int LEN_W       = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] FRAME_PAYLOAD_RESET = 32'h0001_0000;
    localparam logic [31:0] LEN_SHORT_LIMIT     = 32'd126;
    localparam logic [31:0] LEN_MID_LIMIT       = 32'h0001_0000;
    localparam logic [7:0]  FIN_BIT             = 8'h80;
    localparam logic        MASK_BIT            = 1'b1;
    localparam logic [6:0]  LEN_CODE_16         = 7'd126;
    localparam logic [6:0]  LEN_CODE_64         = 7'd127;

    typedef enum logic [1:0] {
        LC_SHORT,
        LC_MID,
        LC_LONG
    } len_class_t;

    typedef struct packed {
        logic             hdr;
        logic             fin;
        logic [3:0]       opcode;
        len_class_t       len_class;
        logic [LEN_W-1:0] flen;
        logic [31:0]      key;
        logic [7:0]       pbyte;
        logic             last;
    } frame_req_t;

endpackage

// ===== rtl/wft_front.sv =====
// Front end: accepts payload bytes, tracks message and frame state, builds frame requests.
module wft_front
    import wft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        message_start,
    input  logic [3:0]  opcode,
    input  logic [31:0] message_length,
    input  logic        final_message,
    input  logic [31:0] masking_key,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] max_frame_payload,
    input  logic        queue_full,
    output logic        push_valid,
    output frame_req_t  push_req
);

    logic [31:0]      max_payload_reg;
    logic             open_reg;
    logic [LEN_W-1:0] msg_left_reg;
    logic [LEN_W-1:0] frame_left_reg;
    logic [1:0]       lane_reg;
    logic [3:0]       op_reg;
    logic             final_reg;
    logic [31:0]      key_reg;

    logic             accept;
    logic             eff_open;
    logic [LEN_W-1:0] eff_msg_left;
    logic [LEN_W-1:0] eff_frame_left;
    logic [1:0]       eff_lane;
    logic [3:0]       eff_op;
    logic             eff_final;
    logic [31:0]      eff_key;
    logic [31:0]      lim;
    logic             fits;
    logic [LEN_W-1:0] flen;
    logic             new_frame;
    logic [LEN_W-1:0] frame_cnt;
    logic [1:0]       lane;
    logic [1:0]       key_idx;
    logic [LEN_W-1:0] msg_left_next;
    logic [LEN_W-1:0] frame_left_next;
    logic [1:0]       lane_next;
    logic [3:0]       op_next;
    logic             open_next;

    assign in_ready  = !queue_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        eff_open       = message_start ? (message_length[LEN_W-1:0] != '0) : open_reg;
        eff_msg_left   = message_start ? message_length[LEN_W-1:0] : msg_left_reg;
        eff_frame_left = message_start ? '0 : frame_left_reg;
        eff_lane       = message_start ? 2'd0 : lane_reg;
        eff_op         = message_start ? opcode : op_reg;
        eff_final      = message_start ? final_message : final_reg;
        eff_key        = message_start ? masking_key : key_reg;

        lim       = (max_payload_reg == 32'd0) ? 32'd1 : max_payload_reg;
        fits      = (32'(eff_msg_left) <= lim);
        flen      = fits ? eff_msg_left : lim[LEN_W-1:0];
        new_frame = (eff_frame_left == '0);
        frame_cnt = new_frame ? flen : eff_frame_left;
        lane      = new_frame ? 2'd0 : eff_lane;
        key_idx   = 2'd3 - lane;

        frame_left_next = frame_cnt - LEN_W'(1);
        msg_left_next   = eff_msg_left - LEN_W'(1);
        lane_next       = lane + 2'd1;
        op_next         = new_frame ? 4'd0 : eff_op;
        open_next       = eff_open && (msg_left_next != '0);

        push_req.hdr    = new_frame;
        push_req.fin    = fits && eff_final;
        push_req.opcode = eff_op;
        if (32'(flen) < LEN_SHORT_LIMIT)
        begin
            push_req.len_class = LC_SHORT;
        end
        else if (32'(flen) < LEN_MID_LIMIT)
        begin
            push_req.len_class = LC_MID;
        end
        else
        begin
            push_req.len_class = LC_LONG;
        end
        push_req.flen  = flen;
        push_req.key   = eff_key;
        push_req.pbyte = data_byte ^ eff_key[{key_idx, 3'b000} +: 8];
        push_req.last  = (frame_cnt == LEN_W'(1));
    end

    assign push_valid = accept && eff_open;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= FRAME_PAYLOAD_RESET;
            open_reg        <= 1'b0;
            msg_left_reg    <= '0;
            frame_left_reg  <= '0;
            lane_reg        <= 2'd0;
            op_reg          <= 4'd0;
            final_reg       <= 1'b0;
            key_reg         <= 32'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_payload_reg <= max_frame_payload;
            end
            if (accept)
            begin
                open_reg  <= open_next;
                final_reg <= eff_final;
                key_reg   <= eff_key;
                if (eff_open)
                begin
                    msg_left_reg   <= msg_left_next;
                    frame_left_reg <= frame_left_next;
                    lane_reg       <= lane_next;
                    op_reg         <= op_next;
                end
                else
                begin
                    msg_left_reg   <= eff_msg_left;
                    frame_left_reg <= eff_frame_left;
                    lane_reg       <= eff_lane;
                    op_reg         <= eff_op;
                end
            end
        end
    end

endmodule

// ===== rtl/wft_queue.sv =====
// Short request queue between the front end and the byte serializer.
module wft_queue
    import wft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_req_t push_req,
    input  logic       pop,
    output logic       full,
    output logic       head_valid,
    output frame_req_t head
);

    frame_req_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ===== rtl/wft_back.sv =====
// Back end: serializes frame headers and payload bytes into the output register.
module wft_back
    import wft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  frame_req_t head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] frame_byte,
    output logic       frame_last
);

    typedef enum logic [2:0] {
        ST_HDR0,
        ST_HDR1,
        ST_EXT,
        ST_KEY,
        ST_PAY
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic        last_reg;
    logic        last_next;
    logic        fire;
    logic        is_pay;
    logic        keyed;
    logic [63:0] flen64;

    assign fire   = head_valid && (!out_valid_reg || out_ready);
    assign keyed  = (head.key != 32'd0);
    assign flen64 = 64'(head.flen);
    assign pop    = fire && is_pay;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        byte_next  = head.pbyte;
        last_next  = 1'b0;
        is_pay     = 1'b0;
        case (state_reg)
            ST_HDR0:
            begin
                if (head.hdr)
                begin
                    byte_next  = (head.fin ? FIN_BIT : 8'h00) | {4'h0, head.opcode};
                    state_next = ST_HDR1;
                end
                else
                begin
                    last_next = head.last;
                    is_pay    = 1'b1;
                end
            end
            ST_HDR1:
            begin
                case (head.len_class)
                    LC_MID:
                    begin
                        byte_next  = {keyed & MASK_BIT, LEN_CODE_16};
                        state_next = ST_EXT;
                        cnt_next   = 3'd1;
                    end
                    LC_LONG:
                    begin
                        byte_next  = {keyed & MASK_BIT, LEN_CODE_64};
                        state_next = ST_EXT;
                        cnt_next   = 3'd7;
                    end
                    default:
                    begin
                        byte_next  = {keyed & MASK_BIT, head.flen[6:0]};
                        state_next = keyed ? ST_KEY : ST_PAY;
                        cnt_next   = 3'd3;
                    end
                endcase
            end
            ST_EXT:
            begin
                byte_next = flen64[{cnt_reg, 3'b000} +: 8];
                if (cnt_reg == 3'd0)
                begin
                    state_next = keyed ? ST_KEY : ST_PAY;
                    cnt_next   = 3'd3;
                end
                else
                begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            ST_KEY:
            begin
                byte_next = head.key[{cnt_reg[1:0], 3'b000} +: 8];
                if (cnt_reg == 3'd0)
                begin
                    state_next = ST_PAY;
                end
                else
                begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            ST_PAY:
            begin
                last_next  = head.last;
                is_pay     = 1'b1;
                state_next = ST_HDR0;
            end
            default:
            begin
                state_next = ST_HDR0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HDR0;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
            byte_reg      <= 8'h00;
            last_reg      <= 1'b0;
        end
        else if (fire)
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= 1'b1;
            byte_reg      <= byte_next;
            last_reg      <= last_next;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign frame_last = last_reg;

endmodule

// ===== rtl/websocket_frame_transmitter_core.sv =====
// Top level of the WebSocket frame transmitter: front end, request queue, byte serializer.
// A payload byte that continues an open frame adds no header, so a steady payload stream
// runs at one byte per clock while out_ready is high. A frame's first byte follows 2, 4 or
// 10 header bytes plus 4 key bytes when masked. The serializer drives one byte per cycle
// while out_ready is high and so sets the rate; input is taken while the 4-entry request
// queue has room. Bytes with no open message are taken and dropped. The user must write
// max_frame_payload (own valid/ready port, always ready) only while idle; not enforced.
module websocket_frame_transmitter_core
    import wft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        message_start,
    input  logic [3:0]  opcode,
    input  logic [31:0] message_length,
    input  logic        final_message,
    input  logic [31:0] masking_key,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        frame_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] max_frame_payload
);

    logic       push_valid;
    frame_req_t push_req;
    logic       queue_full;
    logic       head_valid;
    frame_req_t head;
    logic       pop;

    wft_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .data_byte         (data_byte),
        .message_start     (message_start),
        .opcode            (opcode),
        .message_length    (message_length),
        .final_message     (final_message),
        .masking_key       (masking_key),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .max_frame_payload (max_frame_payload),
        .queue_full        (queue_full),
        .push_valid        (push_valid),
        .push_req          (push_req)
    );

    wft_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_req   (push_req),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    wft_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

endmodule

// ===== rtl/wft_checker.sv =====
// Port-level checks for the WebSocket frame transmitter, bound to the top level.
module wft_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] frame_byte,
    input logic       frame_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before the request was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(frame_byte) && $stable(frame_last))
        else $error("output request changed while stalled");

    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    a_full_backed: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no output pending");

endmodule

bind websocket_frame_transmitter_core wft_checker u_wft_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .frame_last (frame_last)
);
